@@ src/b2b_pkg.sv @@
// Shared types, constants and a helper function for the BLAKE2b hash engine.
package b2b_pkg;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        is_last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } out_item_t;

    localparam logic [0:0] REG_DIGEST_SIZE = 1'd0;
    localparam logic [0:0] REG_KEY_SIZE    = 1'd1;

    // Commands from controller to datapath.
    typedef struct packed {
        logic init;         // reload chain value and counters
        logic load_word;    // write word into block buffer
        logic flush_block;  // count 128 and start a non-final compression
        logic final_prep;   // pad, set counter, start final compression
        logic round_step;   // run one half round
        logic finish;       // fold state into chain value
        logic key_phase_in; // current item belongs to the key block
    } ctl_cmd_t;

    typedef struct packed {
        logic       key_phase;
        logic       block_pending;
        logic [6:0] digest_len;
    } dp_status_t;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    localparam logic [3:0] SIGMA [12][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}};

    // Keeps the low n bytes of a word, n of eight or more keeps all.
    function automatic logic [63:0] low_bytes(input logic [63:0] w, input logic [7:0] n);
        logic [63:0] mask;
        mask = '0;
        for (int i = 0; i < 8; i++) begin
            if (n > 8'(i)) begin
                mask[i*8 +: 8] = 8'hff;
            end
        end
        return w & mask;
    endfunction

endpackage

@@ src/b2b_gfunc.sv @@
// One BLAKE2b G function: two additions steps with rotations on four state words.
module b2b_gfunc (
    input  logic [63:0] a_in,
    input  logic [63:0] b_in,
    input  logic [63:0] c_in,
    input  logic [63:0] d_in,
    input  logic [63:0] mx,
    input  logic [63:0] my,
    output logic [63:0] a_out,
    output logic [63:0] b_out,
    output logic [63:0] c_out,
    output logic [63:0] d_out
);
    logic [63:0] a1, d1, c1, b1, d1x, b1x, a2, d2x, c2, b2x;

    always_comb begin
        a1    = a_in + b_in + mx;
        d1x   = d_in ^ a1;
        d1    = {d1x[31:0], d1x[63:32]};
        c1    = c_in + d1;
        b1x   = b_in ^ c1;
        b1    = {b1x[23:0], b1x[63:24]};
        a2    = a1 + b1 + my;
        d2x   = d1 ^ a2;
        d_out = {d2x[15:0], d2x[63:16]};
        c2    = c1 + d_out;
        b2x   = b1 ^ c2;
        b_out = {b2x[62:0], b2x[63]};
        a_out = a2;
        c_out = c2;
    end
endmodule

@@ src/b2b_datapath.sv @@
// Datapath: block buffer, chain value, byte counter and the four-lane round unit.
module b2b_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  b2b_pkg::ctl_cmd_t     cmd,
    input  b2b_pkg::in_item_t     item,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_idx,
    input  logic [6:0]            cfg_data,
    input  logic [2:0]            out_idx,
    output logic [63:0]           out_word,
    output b2b_pkg::dp_status_t   status
);
    logic [6:0]  dlen_reg, klen_reg;
    logic [6:0]  dlen_next, klen_next;
    logic [63:0] h_reg [8];
    logic [63:0] cnt_lo_reg, cnt_hi_reg;
    logic [63:0] m_reg [16];
    logic [7:0]  fill_reg;
    logic        pend_reg;
    logic [63:0] v_reg [16];
    logic [4:0]  step_reg;

    logic [6:0]  eff_d, eff_k, eff_dn, eff_kn;
    logic [3:0]  vb;
    logic [7:0]  allow, cnt_add;
    logic [63:0] word_in, lo_sum, cnt_lo_new, cnt_hi_new;
    logic        diag;
    logic [3:0]  rnd;
    logic [63:0] ga [4], gb [4], gc [4], gd [4], gx [4], gy [4];
    logic [63:0] ra [4], rb [4], rc [4], rd [4];
    logic [63:0] p0;

    always_comb begin
        if (!aresetn) begin
            dlen_next = 7'd64;
            klen_next = 7'd0;
        end else begin
            dlen_next = dlen_reg;
            klen_next = klen_reg;
            if (cfg_we) begin
                if (cfg_idx == b2b_pkg::REG_DIGEST_SIZE) begin
                    dlen_next = cfg_data;
                end else begin
                    klen_next = cfg_data;
                end
            end
        end
        eff_d = (dlen_reg == 7'd0) ? 7'd1 : ((dlen_reg > 7'd64) ? 7'd64 : dlen_reg);
        eff_k = (klen_reg > 7'd64) ? 7'd64 : klen_reg;
        eff_dn = (dlen_next == 7'd0) ? 7'd1 : ((dlen_next > 7'd64) ? 7'd64 : dlen_next);
        eff_kn = (klen_next > 7'd64) ? 7'd64 : klen_next;
        vb = (item.valid_bytes > 4'd8) ? 4'd8 : item.valid_bytes;
        allow = ({1'b0, eff_k} > fill_reg) ? ({1'b0, eff_k} - fill_reg) : 8'd0;
        if (cmd.key_phase_in) begin
            word_in = b2b_pkg::low_bytes(item.data_word, allow);
        end else if (item.is_last) begin
            word_in = b2b_pkg::low_bytes(item.data_word, {4'd0, vb});
        end else begin
            word_in = item.data_word;
        end
        cnt_add = (cmd.key_phase_in || !item.is_last) ? 8'd8 : {4'd0, vb};
        status.key_phase = (eff_k != 7'd0) && (cnt_lo_reg == '0) && (cnt_hi_reg == '0)
                           && !pend_reg;
        status.block_pending = pend_reg;
        status.digest_len = eff_d;
        p0 = {32'd0, 8'd1, 8'd1, 1'b0, eff_kn, 1'b0, eff_dn};
        lo_sum = cnt_lo_reg + (cmd.flush_block ? 64'd128
                 : {56'd0, (cmd.key_phase_in ? 8'd128 : fill_reg)});
        cnt_lo_new = lo_sum;
        cnt_hi_new = cnt_hi_reg + ((lo_sum < cnt_lo_reg) ? 64'd1 : 64'd0);
        out_word = h_reg[out_idx];
        diag = step_reg[0];
        rnd = step_reg[4:1];
        for (int g = 0; g < 4; g++) begin
            if (!diag) begin
                ga[g] = v_reg[g];
                gb[g] = v_reg[4 + g];
                gc[g] = v_reg[8 + g];
                gd[g] = v_reg[12 + g];
                gx[g] = m_reg[b2b_pkg::SIGMA[rnd][2*g]];
                gy[g] = m_reg[b2b_pkg::SIGMA[rnd][2*g+1]];
            end else begin
                ga[g] = v_reg[g];
                gb[g] = v_reg[4 + ((g + 1) % 4)];
                gc[g] = v_reg[8 + ((g + 2) % 4)];
                gd[g] = v_reg[12 + ((g + 3) % 4)];
                gx[g] = m_reg[b2b_pkg::SIGMA[rnd][8 + 2*g]];
                gy[g] = m_reg[b2b_pkg::SIGMA[rnd][8 + 2*g + 1]];
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        b2b_gfunc u_g (
            .a_in(ga[g]), .b_in(gb[g]), .c_in(gc[g]), .d_in(gd[g]),
            .mx(gx[g]), .my(gy[g]),
            .a_out(ra[g]), .b_out(rb[g]), .c_out(rc[g]), .d_out(rd[g])
        );
    end

    always_ff @(posedge aclk) begin
        dlen_reg <= dlen_next;
        klen_reg <= klen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.init) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= (i == 0) ? (b2b_pkg::IV[0] ^ p0) : b2b_pkg::IV[i];
            end
            cnt_lo_reg <= '0;
            cnt_hi_reg <= '0;
            fill_reg <= '0;
            pend_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            if (cmd.flush_block || cmd.final_prep) begin
                cnt_lo_reg <= cnt_lo_new;
                cnt_hi_reg <= cnt_hi_new;
                step_reg <= '0;
                for (int i = 0; i < 8; i++) begin
                    v_reg[i] <= h_reg[i];
                end
                for (int i = 0; i < 4; i++) begin
                    v_reg[8 + i] <= b2b_pkg::IV[i];
                end
                v_reg[12] <= b2b_pkg::IV[4] ^ cnt_lo_new;
                v_reg[13] <= b2b_pkg::IV[5] ^ cnt_hi_new;
                v_reg[14] <= cmd.final_prep ? ~b2b_pkg::IV[6] : b2b_pkg::IV[6];
                v_reg[15] <= b2b_pkg::IV[7];
                if (cmd.final_prep) begin
                    for (int i = 0; i < 16; i++) begin
                        if ((fill_reg + 8'd7) < 8'(i * 8 + 8)) begin
                            m_reg[i] <= '0;
                        end
                    end
                end
                if (cmd.flush_block) begin
                    fill_reg <= '0;
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.load_word) begin
                m_reg[fill_reg[6:3]] <= word_in;
                if ((fill_reg + cnt_add) >= 8'd128) begin
                    fill_reg <= 8'd128;
                    pend_reg <= 1'b1;
                end else begin
                    fill_reg <= fill_reg + cnt_add;
                end
            end
            if (cmd.round_step) begin
                step_reg <= step_reg + 5'd1;
                for (int g = 0; g < 4; g++) begin
                    v_reg[g] <= ra[g];
                    if (!diag) begin
                        v_reg[4 + g] <= rb[g];
                        v_reg[8 + g] <= rc[g];
                        v_reg[12 + g] <= rd[g];
                    end else begin
                        v_reg[4 + ((g + 1) % 4)] <= rb[g];
                        v_reg[8 + ((g + 2) % 4)] <= rc[g];
                        v_reg[12 + ((g + 3) % 4)] <= rd[g];
                    end
                end
            end
            if (cmd.finish) begin
                for (int i = 0; i < 8; i++) begin
                    h_reg[i] <= h_reg[i] ^ v_reg[i] ^ v_reg[8 + i];
                end
            end
        end
    end
endmodule

@@ src/b2b_ctrl.sv @@
// Controller state machine: sequences word loads, compressions and digest output.
module b2b_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  b2b_pkg::in_item_t     s_item,
    input  logic                  cfg_we,
    input  b2b_pkg::dp_status_t   status,
    output b2b_pkg::ctl_cmd_t     cmd,
    output logic [2:0]            out_idx,
    output logic                  out_load,
    output logic                  out_last,
    input  logic                  out_free
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FOLD  = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       fin_reg, fin_next;
    logic       kp_reg, kp_next;
    logic [2:0] idx_reg, idx_next;
    logic [3:0] nwords;
    logic       nonempty;
    logic       need_flush;

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        fin_next = fin_reg;
        kp_next = kp_reg;
        idx_next = idx_reg;
        cmd = '0;
        s_ready = 1'b0;
        out_load = 1'b0;
        nwords = 4'(({1'b0, status.digest_len} + 8'd7) >> 3);
        out_idx = idx_reg;
        out_last = (4'({1'b0, idx_reg}) + 4'd1) == nwords;
        nonempty = status.key_phase || !s_item.is_last || (s_item.valid_bytes != 4'd0);
        need_flush = nonempty && status.block_pending;
        cmd.key_phase_in = kp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !cfg_we && !need_flush;
                cmd.key_phase_in = status.key_phase;
                if (s_valid && !cfg_we) begin
                    if (need_flush) begin
                        // The waiting block is compressed before the word is taken.
                        cmd.flush_block = 1'b1;
                        fin_next = 1'b0;
                        step_next = '0;
                        state_next = ST_ROUND;
                    end else begin
                        kp_next = status.key_phase;
                        cmd.load_word = nonempty;
                        if (s_item.is_last) begin
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd23) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.finish = 1'b1;
                idx_next = '0;
                fin_next = 1'b0;
                state_next = fin_reg ? ST_EMIT : ST_IDLE;
            end
            ST_LOAD: begin
                cmd.final_prep = 1'b1;
                step_next = '0;
                fin_next = 1'b1;
                state_next = ST_ROUND;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    idx_next = idx_reg + 3'd1;
                    if (out_last) begin
                        cmd.init = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_we) begin
            cmd = '0;
            cmd.init = 1'b1;
            out_load = 1'b0;
            fin_next = 1'b0;
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            fin_reg <= 1'b0;
            kp_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            fin_reg <= fin_next;
            kp_reg <= kp_next;
            idx_reg <= idx_next;
        end
    end
endmodule

@@ src/blake2b_hash_engine_top.sv @@
// Top level of the BLAKE2b hash engine.
// The s_ channel takes one little-endian 64-bit message word per transfer;
// is_last marks the final word and valid_bytes gives its byte count.
// After the final word the m_ channel delivers ceil(digest size/8) digest
// words, word_index counting up, digest_last on the final one.
// A non-final word is taken when offered, so words can follow every cycle,
// unless a full block is waiting and the word adds bytes; then s_ready stays
// low while that block is compressed (a setup step, the half rounds on four
// parallel G units and a fold step), and the word is taken after that.
// After the final word is taken, a setup step, the half rounds and a fold step
// run before the first digest word shows on m_valid; the following words
// come one per cycle while m_ready is high.
// The single output register holds a result while the receiver stalls; the
// engine waits for it to drain and takes no input until the last digest word
// sits in the output register.
// A configuration write (cfg_we, cfg_addr, cfg_wdata) restarts the message
// with the new digest and key sizes; write only while the engine is idle.
// Reset (aresetn low, synchronous) sets a 64-byte digest, no key, and starts
// a fresh message.
module blake2b_hash_engine_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b2b_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b2b_pkg::out_item_t  m_data,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_addr,
    input  logic [6:0]          cfg_wdata
);
    b2b_pkg::ctl_cmd_t   cmd;
    b2b_pkg::dp_status_t status;
    logic [2:0]          out_idx;
    logic [63:0]         out_word;
    logic                out_load, out_last, out_free;
    logic                m_valid_reg;
    b2b_pkg::out_item_t  m_data_reg;

    assign out_free = !m_valid_reg || m_ready;

    b2b_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_item(s_data), .cfg_we(cfg_we), .status(status), .cmd(cmd),
        .out_idx(out_idx), .out_load(out_load), .out_last(out_last),
        .out_free(out_free)
    );

    b2b_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .item(s_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_addr), .cfg_data(cfg_wdata),
        .out_idx(out_idx), .out_word(out_word), .status(status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.digest_word <= b2b_pkg::low_bytes(out_word,
                8'({1'b0, status.digest_len} - {2'd0, out_idx, 3'd0}));
            m_data_reg.word_index <= out_idx;
            m_data_reg.digest_last <= out_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;
endmodule

@@ src/b2b_checker.sv @@
// Port-level checker for the BLAKE2b hash engine, bound to the top level.
module b2b_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input b2b_pkg::out_item_t m_data
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result changed while stalled.");

    a_no_in_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.digest_last |-> !s_ready)
        else $error("Input taken while digest words remain.");

    a_index_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.digest_last |=> !m_valid ||
        m_data.word_index == $past(m_data.word_index) + 3'd1)
        else $error("Digest word index did not advance.");
endmodule

bind blake2b_hash_engine_top b2b_checker u_b2b_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
